[hw/rtl/srd_pkg.sv]
// Shared constants and types for the signed restoring divider.
package srd_pkg;

  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef struct packed {
    logic neg;
    logic dbz;
    logic ovf;
  } srd_flags_t;

endpackage

[hw/rtl/srd_prep.sv]
// Input stage: operand magnitudes, result sign and special-case flags.
module srd_prep #(
  parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [DATA_WIDTH-1:0]  dividend,
  input  logic signed [DATA_WIDTH-1:0]  divisor,
  input  logic                          take,
  output logic                          ready,
  output logic                          valid,
  output logic        [DATA_WIDTH-1:0]  num,
  output logic        [DATA_WIDTH-1:0]  den,
  output srd_pkg::srd_flags_t           flags
);
  import srd_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MinNeg = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic [DATA_WIDTH-1:0] a_u;
  logic [DATA_WIDTH-1:0] b_u;
  logic [DATA_WIDTH-1:0] num_next;
  logic [DATA_WIDTH-1:0] den_next;
  srd_flags_t            flags_next;

  always_comb begin
    a_u              = dividend;
    b_u              = divisor;
    num_next         = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
    den_next         = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
    flags_next.neg   = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
    flags_next.dbz   = (b_u == '0);
    flags_next.ovf   = (a_u == MinNeg) && (b_u == '1);
  end

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      num   <= num_next;
      den   <= den_next;
      flags <= flags_next;
    end
  end

endmodule

[hw/rtl/srd_step.sv]
// One restoring division step: one quotient bit per pipeline stage.
module srd_step #(
  parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [DATA_WIDTH-1:0]  rem_in,
  input  logic [DATA_WIDTH-1:0]  num_in,
  input  logic [DATA_WIDTH-1:0]  den_in,
  input  srd_pkg::srd_flags_t    flags_in,
  input  logic                   take,
  output logic                   ready,
  output logic                   valid,
  output logic [DATA_WIDTH-1:0]  rem,
  output logic [DATA_WIDTH-1:0]  num,
  output logic [DATA_WIDTH-1:0]  den,
  output srd_pkg::srd_flags_t    flags
);
  import srd_pkg::*;

  logic [DATA_WIDTH+1:0] diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_next;
  logic [DATA_WIDTH-1:0] num_next;

  always_comb begin
    diff     = {1'b0, rem_in, num_in[DATA_WIDTH-1]} - {2'b00, den_in};
    qbit     = !diff[DATA_WIDTH+1];
    rem_next = qbit ? diff[DATA_WIDTH-1:0] : {rem_in[DATA_WIDTH-2:0], num_in[DATA_WIDTH-1]};
    num_next = {num_in[DATA_WIDTH-2:0], qbit};
  end

  assign ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      rem   <= rem_next;
      num   <= num_next;
      den   <= den_in;
      flags <= flags_in;
    end
  end

endmodule

[hw/rtl/srd_post.sv]
// Output stage: sign fix-up, special-case select and output register.
module srd_post #(
  parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic        [DATA_WIDTH-1:0]  num_in,
  input  srd_pkg::srd_flags_t           flags_in,
  output logic                          ready,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  quotient,
  output logic                          overflow_saturated,
  output logic                          divide_by_zero
);
  import srd_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    if (flags_in.dbz) begin
      q_next = '1;
    end else if (flags_in.ovf) begin
      q_next = MaxPos;
    end else if (flags_in.neg) begin
      q_next = ~num_in + 1'b1;
    end else begin
      q_next = num_in;
    end
  end

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      quotient           <= q_next;
      overflow_saturated <= flags_in.ovf && !flags_in.dbz;
      divide_by_zero     <= flags_in.dbz;
    end
  end

endmodule

[hw/rtl/signed_restoring_divider_unit.sv]
// Top level of the pipelined signed restoring divider.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, dividend, divisor     | request in
//   out     | out_valid, out_stall, quotient,           | request out
//           | overflow_saturated, divide_by_zero        |
//
// Requests pass through DATA_WIDTH + 2 register stages: one input stage, one
// stage per quotient bit (one DATA_WIDTH + 2 bit subtract each), one output
// register. One request is taken every cycle while in_stall is low; empty
// stages fill even while the output is stalled.
// Reset clears every stage valid bit; payload registers are not reset.
// A stalled output holds its request; stages behind it advance until full.
module signed_restoring_divider_unit #(
  parameter int DATA_WIDTH = srd_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  dividend,
  input  logic signed [DATA_WIDTH-1:0]  divisor,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  quotient,
  output logic                          overflow_saturated,
  output logic                          divide_by_zero
);
  import srd_pkg::*;

  logic                  vld_s   [0:DATA_WIDTH];
  logic                  rdy_s   [0:DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] rem_s   [0:DATA_WIDTH-1];
  logic [DATA_WIDTH-1:0] num_s   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den_s   [0:DATA_WIDTH-1];
  srd_flags_t            flags_s [0:DATA_WIDTH];

  assign in_stall = !rdy_s[0];
  assign rem_s[0] = '0;

  srd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .dividend (dividend),
    .divisor  (divisor),
    .take     (rdy_s[1]),
    .ready    (rdy_s[0]),
    .valid    (vld_s[0]),
    .num      (num_s[0]),
    .den      (den_s[0]),
    .flags    (flags_s[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    if (i < DATA_WIDTH - 1) begin : g_mid
      srd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (vld_s[i]),
        .rem_in   (rem_s[i]),
        .num_in   (num_s[i]),
        .den_in   (den_s[i]),
        .flags_in (flags_s[i]),
        .take     (rdy_s[i+2]),
        .ready    (rdy_s[i+1]),
        .valid    (vld_s[i+1]),
        .rem      (rem_s[i+1]),
        .num      (num_s[i+1]),
        .den      (den_s[i+1]),
        .flags    (flags_s[i+1])
      );
    end else begin : g_last
      srd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
        .clk      (clk),
        .rst      (rst),
        .in_valid (vld_s[i]),
        .rem_in   (rem_s[i]),
        .num_in   (num_s[i]),
        .den_in   (den_s[i]),
        .flags_in (flags_s[i]),
        .take     (rdy_s[i+2]),
        .ready    (rdy_s[i+1]),
        .valid    (vld_s[i+1]),
        .rem      (),
        .num      (num_s[i+1]),
        .den      (),
        .flags    (flags_s[i+1])
      );
    end
  end

  srd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (vld_s[DATA_WIDTH]),
    .num_in             (num_s[DATA_WIDTH]),
    .flags_in           (flags_s[DATA_WIDTH]),
    .ready              (rdy_s[DATA_WIDTH+1]),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .quotient           (quotient),
    .overflow_saturated (overflow_saturated),
    .divide_by_zero     (divide_by_zero)
  );

endmodule
